[rtl/core/ukt_pkg.sv]
`timescale 1ns / 1ps
// Package for the unordered key table: request and response payloads, op and
// status codes, the record that travels down the cell chain, and the stored entry.
// No dependencies.
package ukt_pkg;

   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int OP_BITS    = 3;
   localparam int CNT_BITS   = 5;

   localparam logic [CNT_BITS-1:0] CAP_RESET = 5'd16;

   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT = 3'd0,
      OP_QUERY  = 3'd1,
      OP_REMOVE = 3'd2,
      OP_FIRST  = 3'd3,
      OP_NEXT   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_RUN    = 2'd1,
      S_FINISH = 2'd2
   } state_type;

   typedef struct packed {
      logic [OP_BITS-1:0]    op;
      logic [KEY_BITS-1:0]   match_key;
      logic [VALUE_BITS-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [KEY_BITS-1:0]   found_key;
      logic [VALUE_BITS-1:0] found_value;
      logic [CNT_BITS-1:0]   entry_count;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   // Record handed from cell to cell. For an insert, found means the insert
   // was accepted; for the other ops it means an entry has been picked up.
   typedef struct packed {
      logic                  run;
      logic [OP_BITS-1:0]    op;
      logic                  found;
      logic [CNT_BITS-1:0]   target;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } cell_rec_type;

endpackage

[rtl/core/unordered_key_table_unit.sv]
`timescale 1ns / 1ps
// Top level of the unordered key table: a controller and a chain of DEPTH cells.
// Depends on ukt_pkg, ukt_ctrl and ukt_cell.
//
//   Port group   Dir   Handshake            Carries
//   req_*        in    req_valid/req_stall  op, match_key, element_value
//   rsp_*        out   rsp_valid/rsp_stall  status, found_key, found_value, entry_count
//   csr_*        in    csr_write_en         capacity (5 bits)
//
// On acceptance the request record is registered in the controller and walks the
// cell chain one cell per clock; the controller then registers the result in a
// pending register and moves it into the response register once that is free.
// One request is in the chain at a time; the next is taken once the previous
// result has moved into the response register, even if that response is stalled.
// Reset is synchronous and active high; it clears the count, cursor and state
// and sets the capacity to 16. Stored entries are not cleared.
module unordered_key_table_unit #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  ukt_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ukt_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_en,
   input  logic [ukt_pkg::CNT_BITS-1:0]  csr_write_data
);
   import ukt_pkg::*;

   // The record chain: rec[0] enters the first cell, rec[DEPTH] leaves the last.
   cell_rec_type        rec [DEPTH+1];
   // Each cell's stored entry, read by its left neighbor during a removal shift.
   entry_type           ent [DEPTH];
   logic [CNT_BITS-1:0] count;

   ukt_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rec_head       (rec[0]),
      .rec_tail       (rec[DEPTH]),
      .count          (count)
   );

   // Each cell compares its own key as the record passes, so a search or a
   // cursor fetch is resolved by the time the record leaves the last cell.
   // A removal closes the gap cell by cell right behind the record.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type right;
      if (i == DEPTH - 1) begin : g_last
         assign right = '0;
      end else begin : g_mid
         assign right = ent[i+1];
      end

      ukt_cell #(
         .INDEX(i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .rec_in      (rec[i]),
         .count       (count),
         .right_entry (right),
         .rec_out     (rec[i+1]),
         .entry_out   (ent[i])
      );
   end

endmodule

[rtl/core/ukt_cell.sv]
`timescale 1ns / 1ps
// One table cell: holds a single key/value entry and passes the request record
// to the next cell each cycle. Depends on ukt_pkg.
module ukt_cell #(
   parameter int INDEX = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ukt_pkg::cell_rec_type                rec_in,
   input  logic [ukt_pkg::CNT_BITS-1:0]         count,
   input  ukt_pkg::entry_type                   right_entry,
   output ukt_pkg::cell_rec_type                rec_out,
   output ukt_pkg::entry_type                   entry_out
);
   import ukt_pkg::*;

   localparam logic [CNT_BITS-1:0] MY_IDX   = CNT_BITS'(INDEX);
   localparam logic [CNT_BITS-1:0] NEXT_IDX = CNT_BITS'(INDEX + 1);

   entry_type    entry_ff;
   cell_rec_type rec_ff;
   cell_rec_type rec_in_nxt;
   logic         hit;
   logic         write_en;
   logic         shift_en;
   logic         is_search;
   logic         is_fetch;

   always_comb begin
      is_search = (rec_in.op == OP_QUERY) || (rec_in.op == OP_REMOVE);
      is_fetch  = (rec_in.op == OP_FIRST) || (rec_in.op == OP_NEXT);
      hit = (MY_IDX < count) &&
            ((is_search && !rec_in.found && (entry_ff.key == rec_in.key)) ||
             (is_fetch && (rec_in.target == MY_IDX)));
      rec_in_nxt = rec_in;
      if (hit) begin
         rec_in_nxt.found = 1'b1;
         rec_in_nxt.key   = entry_ff.key;
         rec_in_nxt.value = entry_ff.value;
      end
   end

   // An accepted insert lands in the cell just past the last valid entry.
   assign write_en = rec_in.run && (rec_in.op == OP_INSERT) && rec_in.found &&
                     (count == MY_IDX);

   // Once the removed entry lies at or before this cell, pull the right
   // neighbor's entry in, as long as that neighbor is valid.
   assign shift_en = rec_ff.run && (rec_ff.op == OP_REMOVE) && rec_ff.found &&
                     (NEXT_IDX < count);

   always_ff @(posedge clock) begin
      if (write_en) begin
         entry_ff.key   <= rec_in.key;
         entry_ff.value <= rec_in.value;
      end else if (shift_en) begin
         entry_ff <= right_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.run <= 1'b0;
      end else begin
         rec_ff <= rec_in_nxt;
      end
   end

   assign rec_out   = rec_ff;
   assign entry_out = entry_ff;

endmodule

[rtl/core/ukt_ctrl.sv]
`timescale 1ns / 1ps
// Controller: request intake, count, cursor and capacity registers, result
// assembly and the response register. Depends on ukt_pkg.
module ukt_ctrl #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  ukt_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ukt_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_en,
   input  logic [ukt_pkg::CNT_BITS-1:0]  csr_write_data,
   output ukt_pkg::cell_rec_type         rec_head,
   input  ukt_pkg::cell_rec_type         rec_tail,
   output logic [ukt_pkg::CNT_BITS-1:0]  count
);
   import ukt_pkg::*;

   localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(DEPTH);

   state_type           state_ff, state_in;
   cell_rec_type        rec_ff, rec_in;
   logic [CNT_BITS-1:0] cursor_ff, cursor_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] cap_ff;
   logic [CNT_BITS-1:0] eff_cap;
   rsp_type             pend_ff, pend_in;
   rsp_type             rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;
   logic                tail_done;
   logic                rsp_load;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_RUN;
         S_RUN:    if (rec_tail.run) state_in = S_FINISH;
         S_FINISH: if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall = 1'b1;
      tail_done = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         S_IDLE:   req_stall = 1'b0;
         S_RUN:    tail_done = rec_tail.run;
         S_FINISH: rsp_load  = !rsp_valid_ff || !rsp_stall;
         default:  req_stall = 1'b1;
      endcase
   end

   assign accept  = req_valid && !req_stall;
   assign eff_cap = (cap_ff > DEPTH_CNT) ? DEPTH_CNT : cap_ff;

   // Record that enters the chain, and the cursor move it implies.
   always_comb begin
      cursor_in = cursor_ff;
      if (req_data.op == OP_FIRST) begin
         cursor_in = '0;
      end else if ((req_data.op == OP_NEXT) && (cursor_ff < count_ff)) begin
         cursor_in = cursor_ff + 1'b1;
      end
      rec_in.run    = accept;
      rec_in.op     = req_data.op;
      rec_in.found  = (req_data.op == OP_INSERT) && (count_ff < eff_cap);
      rec_in.target = cursor_in;
      rec_in.key    = req_data.match_key;
      rec_in.value  = req_data.element_value;
   end

   // Result from the record leaving the last cell.
   always_comb begin
      count_in            = count_ff;
      pend_in.status      = ST_MISS;
      pend_in.found_key   = '0;
      pend_in.found_value = '0;
      case (rec_tail.op) inside
         OP_INSERT: begin
            pend_in.status = rec_tail.found ? ST_OK : ST_FULL;
            if (rec_tail.found) count_in = count_ff + 1'b1;
         end
         OP_QUERY, OP_REMOVE, OP_FIRST, OP_NEXT: begin
            if (rec_tail.found) begin
               pend_in.status      = ST_OK;
               pend_in.found_key   = rec_tail.key;
               pend_in.found_value = rec_tail.value;
               if (rec_tail.op == OP_REMOVE) count_in = count_ff - 1'b1;
            end
         end
         default: pend_in.status = ST_MISS;
      endcase
      pend_in.entry_count = count_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rec_ff.run   <= 1'b0;
         cursor_ff    <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rec_ff       <= rec_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) cursor_ff <= cursor_in;
         if (tail_done) count_ff <= count_in;
         if (csr_write_en) cap_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (tail_done) pend_ff <= pend_in;
      if (rsp_load) rsp_ff <= pend_ff;
   end

   assign rec_head  = rec_ff;
   assign count     = count_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
